/* rtl/cmps_pkg.sv */
package cmps_pkg;

    // Stream widths: fields packed from bit 0 upward, padded to whole bytes
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 152;

    // Flag decode
    localparam int          REVERSE_BIT   = 4;
    localparam logic [11:0] UNMAPPED_FLAG = 12'd4;

    // Read kind carried on tuser
    localparam logic KIND_READ_ONE = 1'b0;

    typedef enum logic [1:0] {
        ORIENT_SAME = 2'd0,
        ORIENT_IN   = 2'd1,
        ORIENT_OUT  = 2'd2
    } orient_t;

    typedef struct packed {
        logic [7:0]  chrom;
        logic        rev;
        logic        unm;
        logic [31:0] pos;
        logic [15:0] seq_len;
    } map_entry_t;

    typedef struct packed {
        logic [31:0] group_number;
        logic [7:0]  chrom_one;
        logic [31:0] end_one;
        logic [7:0]  chrom_two;
        logic [31:0] end_two;
        logic        strand_one;
        logic        strand_two;
        logic [32:0] insert_size;
        orient_t     orientation;
        logic        overflowed;
    } result_t;

    typedef struct packed {
        logic load;
        logic init;
        logic rd_p;
        logic rd_q;
        logic fetch;
        logic calc;
        logic emit;
        logic close;
    } dp_cmd_t;

    typedef struct packed {
        logic any_empty;
        logic out_stall;
    } dp_stat_t;

endpackage

/* rtl/cmps_dp.sv */
module cmps_dp
    import cmps_pkg::*;
#(
    parameter int MAX_MAPPINGS = 16,
    localparam int CW = $clog2(MAX_MAPPINGS + 1),
    localparam int IW = (MAX_MAPPINGS > 1) ? $clog2(MAX_MAPPINGS) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  dp_cmd_t       cmd,
    input  logic [IW-1:0] rd_p_idx,
    input  logic [IW-1:0] rd_q_idx,
    input  logic          in_kind,
    input  map_entry_t    in_entry,
    output dp_stat_t      stat,
    output logic [CW-1:0] first_cnt,
    output logic [CW-1:0] second_cnt,
    output logic          m_valid,
    input  logic          m_ready,
    output result_t       m_result
);

    map_entry_t first_mem  [MAX_MAPPINGS];
    map_entry_t second_mem [MAX_MAPPINGS];

    logic [CW-1:0] first_cnt_reg, second_cnt_reg;
    logic          drop_reg;
    logic [31:0]   group_reg;

    map_entry_t    p_reg, q_reg;
    logic [IW-1:0] p_idx_reg, q_idx_reg;
    logic          q_vld_reg;

    logic [31:0]   d_next, d_reg;
    logic          qual_next;
    logic          d_vld_reg;
    logic [IW-1:0] d_i_reg, d_j_reg;

    logic          found_reg;
    logic [31:0]   best_reg;
    logic [IW-1:0] b1_reg, b2_reg;

    logic [31:0]   e1_reg, e2_reg;
    logic          mapped;
    result_t       res_next, res_reg;
    logic          m_valid_reg;

    logic first_full, second_full;

    function automatic logic [31:0] five_end(input map_entry_t m);
        logic signed [33:0] sum;
        logic [31:0]        res;
        sum = $signed({2'b00, m.pos}) + $signed({18'd0, m.seq_len}) - 34'sd1;
        if (!m.rev) begin
            res = m.pos;
        end else if (sum < 0) begin
            res = '0;
        end else if (sum[32]) begin
            res = '1;
        end else begin
            res = sum[31:0];
        end
        return res;
    endfunction

    assign first_full  = (first_cnt_reg  == CW'(MAX_MAPPINGS));
    assign second_full = (second_cnt_reg == CW'(MAX_MAPPINGS));

    // Store writes
    always_ff @(posedge aclk) begin
        if (cmd.load && in_kind == KIND_READ_ONE && !first_full) begin
            first_mem[first_cnt_reg[IW-1:0]] <= in_entry;
        end
        if (cmd.load && in_kind != KIND_READ_ONE && !second_full) begin
            second_mem[second_cnt_reg[IW-1:0]] <= in_entry;
        end
    end

    // Fill counts, drop mark, group count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            drop_reg       <= 1'b0;
            group_reg      <= '0;
        end else if (cmd.close) begin
            first_cnt_reg  <= '0;
            second_cnt_reg <= '0;
            drop_reg       <= 1'b0;
            group_reg      <= group_reg + 32'd1;
        end else if (cmd.load) begin
            if (in_kind == KIND_READ_ONE) begin
                if (first_full) begin
                    drop_reg <= 1'b1;
                end else begin
                    first_cnt_reg <= first_cnt_reg + CW'(1);
                end
            end else begin
                if (second_full) begin
                    drop_reg <= 1'b1;
                end else begin
                    second_cnt_reg <= second_cnt_reg + CW'(1);
                end
            end
        end
    end

    // Registered store reads
    always_ff @(posedge aclk) begin
        if (cmd.rd_p) begin
            p_reg     <= first_mem[rd_p_idx];
            p_idx_reg <= rd_p_idx;
        end else if (cmd.fetch) begin
            p_reg <= first_mem[b1_reg];
        end
        if (cmd.rd_q) begin
            q_reg     <= second_mem[rd_q_idx];
            q_idx_reg <= rd_q_idx;
        end else if (cmd.fetch) begin
            q_reg <= second_mem[b2_reg];
        end
    end

    // Distance stage
    always_comb begin
        d_next    = (p_reg.pos > q_reg.pos) ? (p_reg.pos - q_reg.pos)
                                            : (q_reg.pos - p_reg.pos);
        qual_next = (p_reg.chrom == q_reg.chrom) && !p_reg.unm && !q_reg.unm
                    && (d_next != 32'd0);
    end

    always_ff @(posedge aclk) begin
        d_reg   <= d_next;
        d_i_reg <= p_idx_reg;
        d_j_reg <= q_idx_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            q_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
        end else begin
            q_vld_reg <= cmd.rd_q;
            d_vld_reg <= q_vld_reg && qual_next;
        end
    end

    // Best pair update; strict compare keeps the first pair on ties
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
            best_reg  <= '1;
            b1_reg    <= '0;
            b2_reg    <= '0;
        end else if (cmd.init) begin
            found_reg <= 1'b0;
            best_reg  <= '1;
            b1_reg    <= '0;
            b2_reg    <= '0;
        end else if (d_vld_reg && (!found_reg || d_reg < best_reg)) begin
            found_reg <= 1'b1;
            best_reg  <= d_reg;
            b1_reg    <= d_i_reg;
            b2_reg    <= d_j_reg;
        end
    end

    // Five-prime ends of the chosen pair
    always_ff @(posedge aclk) begin
        if (cmd.calc) begin
            e1_reg <= five_end(p_reg);
            e2_reg <= five_end(q_reg);
        end
    end

    always_comb begin
        mapped                = !p_reg.unm && !q_reg.unm;
        res_next.group_number = group_reg;
        res_next.chrom_one    = p_reg.chrom;
        res_next.end_one      = e1_reg;
        res_next.chrom_two    = q_reg.chrom;
        res_next.end_two      = e2_reg;
        res_next.strand_one   = p_reg.rev;
        res_next.strand_two   = q_reg.rev;
        res_next.overflowed   = drop_reg;
        if (p_reg.chrom != q_reg.chrom) begin
            res_next.insert_size = '1;
        end else if (e1_reg > e2_reg) begin
            res_next.insert_size = {1'b0, e1_reg - e2_reg};
        end else begin
            res_next.insert_size = {1'b0, e2_reg - e1_reg};
        end
        if (p_reg.rev == q_reg.rev) begin
            res_next.orientation = ORIENT_SAME;
        end else if (e1_reg < e2_reg) begin
            res_next.orientation = p_reg.rev ? ORIENT_OUT : ORIENT_IN;
        end else begin
            res_next.orientation = p_reg.rev ? ORIENT_IN : ORIENT_OUT;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit && mapped) begin
            res_reg <= res_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit && mapped) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign stat.any_empty = (first_cnt_reg == '0) || (second_cnt_reg == '0);
    assign stat.out_stall = m_valid_reg && !m_ready;
    assign first_cnt      = first_cnt_reg;
    assign second_cnt     = second_cnt_reg;
    assign m_valid        = m_valid_reg;
    assign m_result       = res_reg;

endmodule

/* rtl/cmps_ctrl.sv */
module cmps_ctrl
    import cmps_pkg::*;
#(
    parameter int MAX_MAPPINGS = 16,
    localparam int CW = $clog2(MAX_MAPPINGS + 1),
    localparam int IW = (MAX_MAPPINGS > 1) ? $clog2(MAX_MAPPINGS) : 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    input  logic          s_last,
    output logic          s_ready,
    input  dp_stat_t      stat,
    input  logic [CW-1:0] first_cnt,
    input  logic [CW-1:0] second_cnt,
    output dp_cmd_t       cmd,
    output logic [IW-1:0] rd_p_idx,
    output logic [IW-1:0] rd_q_idx
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_READ_P,
        ST_SCAN,
        ST_DRAIN1,
        ST_DRAIN2,
        ST_FETCH,
        ST_CALC,
        ST_EMIT
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid && s_last) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                if (stat.any_empty) begin
                    cmd.close  = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cmd.init   = 1'b1;
                    i_next     = '0;
                    state_next = ST_READ_P;
                end
            end
            ST_READ_P: begin
                cmd.rd_p   = 1'b1;
                j_next     = '0;
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                cmd.rd_q = 1'b1;
                if (j_reg + CW'(1) == second_cnt) begin
                    if (i_reg + CW'(1) == first_cnt) begin
                        state_next = ST_DRAIN1;
                    end else begin
                        i_next     = i_reg + CW'(1);
                        state_next = ST_READ_P;
                    end
                end else begin
                    j_next = j_reg + CW'(1);
                end
            end
            ST_DRAIN1: begin
                state_next = ST_DRAIN2;
            end
            ST_DRAIN2: begin
                state_next = ST_FETCH;
            end
            ST_FETCH: begin
                cmd.fetch  = 1'b1;
                state_next = ST_CALC;
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (!stat.out_stall) begin
                    cmd.emit   = 1'b1;
                    cmd.close  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign rd_p_idx = i_reg[IW-1:0];
    assign rd_q_idx = j_reg[IW-1:0];

endmodule

/* rtl/closest_mapping_pair_select.sv */
// Loading takes one transaction a cycle while the sequencer is idle; after the closing
// transaction the input is held off while the sequencer passes over the read-two store
// once per read-one entry, fetches the winner and emits it; a group with an empty set is
// closed without a search, and a result still waiting at the output holds back the emit.
// Reset (aresetn low, synchronous) clears counts and group number.
module closest_mapping_pair_select
    import cmps_pkg::*;
#(
    parameter int MAX_MAPPINGS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Input mappings
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // chrom[7:0], flag[19:8], pos[51:20], seq_len[67:52], zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // kind[0]
    input  logic [0:0]             s_axis_tuser,
    input  logic                   s_axis_tlast,
    // Chosen pair results
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // group_number[31:0], chrom_one[39:32], end_one[71:40], chrom_two[79:72],
    // end_two[111:80], strand_one[112], strand_two[113], insert_size[146:114],
    // orientation[148:147], overflowed[149], zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int CW = $clog2(MAX_MAPPINGS + 1);
    localparam int IW = (MAX_MAPPINGS > 1) ? $clog2(MAX_MAPPINGS) : 1;

    dp_cmd_t       cmd;
    dp_stat_t      stat;
    logic [CW-1:0] first_cnt, second_cnt;
    logic [IW-1:0] rd_p_idx, rd_q_idx;
    map_entry_t    in_entry;
    logic [11:0]   in_flag;
    result_t       res;

    // Unpack the mapping: keep only the reverse bit and the unmapped test of the flag
    assign in_flag          = s_axis_tdata[19:8];
    assign in_entry.chrom   = s_axis_tdata[7:0];
    assign in_entry.rev     = in_flag[REVERSE_BIT];
    assign in_entry.unm     = (in_flag == UNMAPPED_FLAG);
    assign in_entry.pos     = s_axis_tdata[51:20];
    assign in_entry.seq_len = s_axis_tdata[67:52];

    // Sequencer: load, walk all cross pairs, fetch the winner, emit
    cmps_ctrl #(
        .MAX_MAPPINGS (MAX_MAPPINGS)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_axis_tvalid),
        .s_last     (s_axis_tlast),
        .s_ready    (s_axis_tready),
        .stat       (stat),
        .first_cnt  (first_cnt),
        .second_cnt (second_cnt),
        .cmd        (cmd),
        .rd_p_idx   (rd_p_idx),
        .rd_q_idx   (rd_q_idx)
    );

    // Stores, distance pipeline, best-pair tracking and the output register
    cmps_dp #(
        .MAX_MAPPINGS (MAX_MAPPINGS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .rd_p_idx   (rd_p_idx),
        .rd_q_idx   (rd_q_idx),
        .in_kind    (s_axis_tuser[0]),
        .in_entry   (in_entry),
        .stat       (stat),
        .first_cnt  (first_cnt),
        .second_cnt (second_cnt),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_result   (res)
    );

    // Pack the result, lowest field first, pad to whole bytes
    assign m_axis_tdata = {
        2'b00,
        res.overflowed,
        res.orientation,
        res.insert_size,
        res.strand_two,
        res.strand_one,
        res.end_two,
        res.chrom_two,
        res.end_one,
        res.chrom_one,
        res.group_number
    };

endmodule

/* test/closest_mapping_pair_select_tb.sv */
`timescale 1ns / 100ps

module closest_mapping_pair_select_tb;
    import cmps_pkg::*;

    localparam int          STORE_DEPTH   = 16;
    localparam logic        KIND_READ_TWO = ~KIND_READ_ONE;
    localparam logic [11:0] REVERSE_FLAG  = 12'(1) << REVERSE_BIT;
    localparam logic [32:0] NO_INSERT     = '1;
    localparam int          RANDOM_ITEMS  = 750;
    localparam int          MAX_REPORTS   = 10;
    // Longest search: a full read-one store against a full read-two store
    localparam int          DRAIN_CYCLES  = 1 + STORE_DEPTH * (STORE_DEPTH + 1) + 5 + 120;

    // One candidate mapping as it travels on the input stream
    typedef struct {
        logic        kind;
        logic [7:0]  chrom;
        logic [11:0] flag;
        logic [31:0] pos;
        logic [15:0] seq_len;
        logic        last;
    } mapping_item_t;

    logic                   aclk;
    logic                   aresetn       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // chrom[7:0], flag[19:8], pos[51:20], seq_len[67:52], zero pad
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    // kind[0]
    logic [0:0]             s_axis_tuser  = '0;
    logic                   s_axis_tlast  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // group_number[31:0], chrom_one[39:32], end_one[71:40], chrom_two[79:72],
    // end_two[111:80], strand_one[112], strand_two[113], insert_size[146:114],
    // orientation[148:147], overflowed[149], zero pad
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // Mappings still to be offered, and chosen pairs still to arrive
    mapping_item_t pending_mappings[$];
    result_t       chosen_pair_q[$];

    // Shadow of the block: both mapping stores, their fill levels, drop marker
    map_entry_t    read_one_store [STORE_DEPTH];
    map_entry_t    read_two_store [STORE_DEPTH];
    int            read_one_count  = 0;
    int            read_two_count  = 0;
    logic          mapping_dropped = 1'b0;
    logic [31:0]   group_count     = '0;

    int            mismatch_count  = 0;

    // Driver and receiver pacing
    mapping_item_t on_bus;
    int            tx_wait   = 0;
    bit            tx_burst  = 1'b0;
    int            rx_stall  = 0;
    bit            rx_burst  = 1'b0;
    result_t       got_pair;

    closest_mapping_pair_select #(
        .MAX_MAPPINGS (STORE_DEPTH)
    ) i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Five-prime end: the leftmost base, or the last base on the minus strand,
    // held within the 32-bit position range
    function automatic logic [31:0] five_prime_end(input map_entry_t m);
        longint e;
        e = longint'(m.pos);
        if (m.rev) begin
            e = e + longint'(m.seq_len) - 1;
        end
        if (e < 0) begin
            return '0;
        end
        if (e > longint'(32'hFFFF_FFFF)) begin
            return '1;
        end
        return e[31:0];
    endfunction

    // Store one accepted mapping; on the closing transaction search every
    // cross pair and queue the chosen pair, if the group yields one
    task automatic take_mapping(input mapping_item_t it);
        map_entry_t  e, p, q, a, b;
        logic [31:0] gap, best, e1, e2;
        int          b1, b2;
        logic        found;
        result_t     r;
        e.chrom   = it.chrom;
        e.rev     = it.flag[REVERSE_BIT];
        e.unm     = (it.flag == UNMAPPED_FLAG);
        e.pos     = it.pos;
        e.seq_len = it.seq_len;
        if (it.kind == KIND_READ_ONE) begin
            if (read_one_count < STORE_DEPTH) begin
                read_one_store[read_one_count] = e;
                read_one_count++;
            end else begin
                mapping_dropped = 1'b1;
            end
        end else begin
            if (read_two_count < STORE_DEPTH) begin
                read_two_store[read_two_count] = e;
                read_two_count++;
            end else begin
                mapping_dropped = 1'b1;
            end
        end
        if (!it.last) begin
            return;
        end
        r.group_number = group_count;
        group_count++;
        if (read_one_count > 0 && read_two_count > 0) begin
            found = 1'b0;
            best  = '1;
            b1    = 0;
            b2    = 0;
            for (int i = 0; i < read_one_count; i++) begin
                for (int j = 0; j < read_two_count; j++) begin
                    p = read_one_store[i];
                    q = read_two_store[j];
                    if (p.chrom == q.chrom && !p.unm && !q.unm) begin
                        gap = (p.pos > q.pos) ? p.pos - q.pos : q.pos - p.pos;
                        // zero distance never counts; ties keep the earlier pair
                        if (gap != 0 && (!found || gap < best)) begin
                            found = 1'b1;
                            best  = gap;
                            b1    = i;
                            b2    = j;
                        end
                    end
                end
            end
            a = read_one_store[b1];
            b = read_two_store[b2];
            if (!a.unm && !b.unm) begin
                e1 = five_prime_end(a);
                e2 = five_prime_end(b);
                r.chrom_one   = a.chrom;
                r.end_one     = e1;
                r.chrom_two   = b.chrom;
                r.end_two     = e2;
                r.strand_one  = a.rev;
                r.strand_two  = b.rev;
                r.insert_size = (a.chrom == b.chrom) ?
                                {1'b0, ((e1 > e2) ? e1 - e2 : e2 - e1)} : NO_INSERT;
                if (a.rev == b.rev) begin
                    r.orientation = ORIENT_SAME;
                end else if (e1 < e2) begin
                    r.orientation = a.rev ? ORIENT_OUT : ORIENT_IN;
                end else begin
                    r.orientation = a.rev ? ORIENT_IN : ORIENT_OUT;
                end
                r.overflowed = mapping_dropped;
                chosen_pair_q.insert(chosen_pair_q.size(), r);
            end
        end
        read_one_count  = 0;
        read_two_count  = 0;
        mapping_dropped = 1'b0;
    endtask

    function automatic result_t unpack_pair(input logic [OUT_TDATA_W-1:0] d);
        result_t r;
        r.group_number = d[31:0];
        r.chrom_one    = d[39:32];
        r.end_one      = d[71:40];
        r.chrom_two    = d[79:72];
        r.end_two      = d[111:80];
        r.strand_one   = d[112];
        r.strand_two   = d[113];
        r.insert_size  = d[146:114];
        r.orientation  = orient_t'(d[148:147]);
        r.overflowed   = d[149];
        return r;
    endfunction

    function automatic string describe_pair(input result_t r);
        return $sformatf("grp %0d c1 %0d e1 %h c2 %0d e2 %h s %b%b ins %h or %0d ovf %b",
                         r.group_number, r.chrom_one, r.end_one, r.chrom_two, r.end_two,
                         r.strand_one, r.strand_two, r.insert_size, r.orientation,
                         r.overflowed);
    endfunction

    task automatic push_mapping(input logic kind, input logic [7:0] chrom,
                                input logic [11:0] flag, input logic [31:0] pos,
                                input logic [15:0] seq_len, input logic last);
        mapping_item_t it;
        it.kind    = kind;
        it.chrom   = chrom;
        it.flag    = flag;
        it.pos     = pos;
        it.seq_len = seq_len;
        it.last    = last;
        pending_mappings.insert(pending_mappings.size(), it);
    endtask

    // Driver: present the next mapping once the wait drawn for it has run out;
    // hold the transaction until the block takes it
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                take_mapping(on_bus);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_mappings.size() > 0) begin
                    on_bus = pending_mappings.pop_front();
                    s_axis_tdata  <= {4'b0, on_bus.seq_len, on_bus.pos, on_bus.flag,
                                      on_bus.chrom};
                    s_axis_tuser  <= on_bus.kind;
                    s_axis_tlast  <= on_bus.last;
                    s_axis_tvalid <= 1'b1;
                    // switch now and then between idling and back-to-back runs
                    if ($urandom_range(0, 39) == 0) begin
                        tx_burst = !tx_burst;
                    end
                    tx_wait = tx_burst ? 0 : $urandom_range(0, 15);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each result transaction against the oldest chosen pair,
    // then stall the result channel for a freshly drawn number of cycles
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got_pair = unpack_pair(m_axis_tdata);
                if (chosen_pair_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("unexpected result: %s", describe_pair(got_pair));
                    end
                end else if (got_pair.group_number !== chosen_pair_q[0].group_number
                          || got_pair.chrom_one    !== chosen_pair_q[0].chrom_one
                          || got_pair.end_one      !== chosen_pair_q[0].end_one
                          || got_pair.chrom_two    !== chosen_pair_q[0].chrom_two
                          || got_pair.end_two      !== chosen_pair_q[0].end_two
                          || got_pair.strand_one   !== chosen_pair_q[0].strand_one
                          || got_pair.strand_two   !== chosen_pair_q[0].strand_two
                          || got_pair.insert_size  !== chosen_pair_q[0].insert_size
                          || got_pair.orientation  !== chosen_pair_q[0].orientation
                          || got_pair.overflowed   !== chosen_pair_q[0].overflowed) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("mismatch: expected %s", describe_pair(chosen_pair_q[0]));
                        $display("          actual   %s", describe_pair(got_pair));
                    end
                    void'(chosen_pair_q.pop_front());
                end else begin
                    void'(chosen_pair_q.pop_front());
                end
                if ($urandom_range(0, 29) == 0) begin
                    rx_burst = !rx_burst;
                end
                rx_stall = rx_burst ? 0 : $urandom_range(0, 15);
            end
            if (rx_stall > 0) begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    initial begin
        int          random_items;
        int          shape, n_one, n_two, total;
        bit          scrambled;
        logic        kind;
        logic [7:0]  grp_chrom, chrom;
        logic [31:0] grp_pos, pos;
        logic [11:0] flag;
        logic [15:0] seq_len;

        // Plain pair, inward facing
        push_mapping(KIND_READ_ONE, 8'd1, 12'h000, 32'd1000, 16'd100, 1'b0);
        push_mapping(KIND_READ_TWO, 8'd1, REVERSE_FLAG, 32'd1300, 16'd100, 1'b1);
        // Field extremes: the end of read one saturates
        push_mapping(KIND_READ_ONE, 8'hFF, 12'hFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
        push_mapping(KIND_READ_TWO, 8'hFF, 12'h000, 32'h0000_0000, 16'h0000, 1'b1);
        // Zero-length reverse read at position zero: end clamps to zero
        push_mapping(KIND_READ_ONE, 8'd0, REVERSE_FLAG, 32'd0, 16'd0, 1'b0);
        push_mapping(KIND_READ_TWO, 8'd0, REVERSE_FLAG, 32'd5, 16'd10, 1'b1);
        // No qualifying pair, and the fallback read one is unmapped: no result
        push_mapping(KIND_READ_ONE, 8'd2, UNMAPPED_FLAG, 32'd10, 16'd50, 1'b0);
        push_mapping(KIND_READ_TWO, 8'd2, 12'h000, 32'd20, 16'd50, 1'b1);
        // Different chromosomes: no insert size
        push_mapping(KIND_READ_ONE, 8'd3, 12'h000, 32'd100, 16'd40, 1'b0);
        push_mapping(KIND_READ_TWO, 8'd4, REVERSE_FLAG, 32'd200, 16'd40, 1'b1);
        // Zero distance ignored, tie keeps the first pair, read one out of order
        push_mapping(KIND_READ_ONE, 8'd5, 12'h000, 32'd500, 16'd60, 1'b0);
        push_mapping(KIND_READ_TWO, 8'd5, 12'h000, 32'd500, 16'd60, 1'b0);
        push_mapping(KIND_READ_TWO, 8'd5, REVERSE_FLAG, 32'd520, 16'd60, 1'b0);
        push_mapping(KIND_READ_ONE, 8'd5, 12'h000, 32'd540, 16'd60, 1'b0);
        push_mapping(KIND_READ_TWO, 8'd5, 12'h000, 32'd560, 16'd60, 1'b1);
        // Group closed on a read-one mapping
        push_mapping(KIND_READ_TWO, 8'd6, 12'h000, 32'd50, 16'd30, 1'b0);
        push_mapping(KIND_READ_ONE, 8'd6, REVERSE_FLAG, 32'd80, 16'd30, 1'b1);
        // Read-two set empty at the close: no result
        push_mapping(KIND_READ_ONE, 8'd7, 12'h000, 32'd1, 16'd20, 1'b0);
        push_mapping(KIND_READ_ONE, 8'd7, 12'h000, 32'd2, 16'd20, 1'b1);
        // Outward facing pair
        push_mapping(KIND_READ_ONE, 8'd8, REVERSE_FLAG, 32'd100, 16'd50, 1'b0);
        push_mapping(KIND_READ_TWO, 8'd8, 12'h000, 32'd300, 16'd50, 1'b1);

        // Random groups: mostly well-formed with a few mappings per read on a
        // shared chromosome and nearby positions; some overflow a store, some
        // leave a set empty, some scramble the kinds
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            shape     = $urandom_range(0, 99);
            grp_chrom = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
            case ($urandom_range(0, 9))
                0:       grp_pos = $urandom_range(0, 1500);
                1:       grp_pos = 32'hFFFF_FFFF - $urandom_range(0, 1500);
                default: grp_pos = $urandom;
            endcase
            n_one = $urandom_range(1, 4);
            n_two = $urandom_range(1, 4);
            if (shape < 3) begin
                n_one = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 3);
            end else if (shape < 6) begin
                n_two = $urandom_range(STORE_DEPTH + 1, STORE_DEPTH + 3);
            end else if (shape < 9) begin
                if ($urandom_range(0, 1) == 0) begin
                    n_one = 0;
                end else begin
                    n_two = 0;
                end
            end
            scrambled = (shape >= 9 && shape < 16);
            total     = n_one + n_two;
            for (int k = 0; k < total; k++) begin
                if (scrambled) begin
                    kind = 1'($urandom_range(0, 1));
                end else begin
                    kind = (k < n_one) ? KIND_READ_ONE : KIND_READ_TWO;
                end
                case ($urandom_range(0, 7))
                    0:       chrom = 8'($urandom);
                    1:       chrom = grp_chrom + 8'd1;
                    default: chrom = grp_chrom;
                endcase
                case ($urandom_range(0, 9))
                    0:       flag = UNMAPPED_FLAG;
                    1, 2:    flag = 12'($urandom_range(0, 4095));
                    3, 4, 5: flag = REVERSE_FLAG | (12'($urandom) & 12'h0C3);
                    default: flag = 12'($urandom) & 12'h0C3;
                endcase
                case ($urandom_range(0, 9))
                    0:       pos = grp_pos;
                    1:       pos = $urandom;
                    default: pos = grp_pos + $urandom_range(0, 2000) - 1000;
                endcase
                case ($urandom_range(0, 9))
                    0:       seq_len = 16'($urandom_range(0, 65535));
                    1:       seq_len = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
                    default: seq_len = 16'($urandom_range(20, 300));
                endcase
                push_mapping(kind, chrom, flag, pos, seq_len, k == total - 1);
            end
            random_items += total;
        end

        // Hold reset low, then release it at a clock edge
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every transaction to be taken and every chosen pair to arrive,
        // then give any stray result time to show
        do @(negedge aclk);
        while (pending_mappings.size() > 0 || s_axis_tvalid);
        do @(negedge aclk);
        while (chosen_pair_q.size() > 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatch_count == 0 && chosen_pair_q.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run
    initial begin
        #1000000;
        $display("Verification failed");
        $finish;
    end

endmodule

/* closest_mapping_pair_select.f */
rtl/cmps_pkg.sv
rtl/cmps_dp.sv
rtl/cmps_ctrl.sv
rtl/closest_mapping_pair_select.sv
test/closest_mapping_pair_select_tb.sv
